/* design/sddf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sddf_pkg
// shared types and constants for the signed decimal digit formatter
// ----------------------------------------------------------------------------
package sddf_pkg;

    // code-B digit values
    localparam logic [3:0] CODE_MINUS = 4'd10;
    localparam logic [3:0] CODE_BLANK = 4'd15;

    // out-of-range limits on the magnitude
    localparam logic [31:0] POS_LIMIT = 32'd99999999;
    localparam logic [31:0] NEG_LIMIT = 32'd999999;

    // divide by ten as multiply by reciprocal, exact for any 32-bit operand
    localparam logic [31:0] RECIP_TEN = 32'hCCCCCCCD;
    localparam int          RECIP_SHIFT = 35;

    // input word
    typedef struct packed {
        logic signed [31:0] value;
        logic [3:0]         digit_count;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [3:0] digit_position;
        logic [3:0] digit_code;
        logic       out_of_range;
        logic       last;
    } t_out_word;

    // state carried down the digit pipeline
    typedef struct packed {
        logic        valid;
        logic [31:0] mag;
        logic        sign_pending;
        logic        zero;
        logic [3:0]  count;
        logic        oor;
    } t_dstage;

endpackage

/* design/sddf_prep.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sddf_prep
// entry stage: magnitude, range flag and saturated digit count
// ----------------------------------------------------------------------------
module sddf_prep #(
    parameter int NUM_DIGITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  sddf_pkg::t_in_word i_word,
    output sddf_pkg::t_dstage  o_st
);
    import sddf_pkg::*;

    logic    w_neg;
    t_dstage n_st;
    t_dstage r_st;

    // sign, magnitude and limits
    always_comb begin
        w_neg          = i_word.value[31];
        n_st.valid     = i_accept;
        n_st.mag       = w_neg ? (32'd0 - 32'(i_word.value)) : 32'(i_word.value);
        n_st.zero      = (i_word.value == 32'sd0);
        n_st.sign_pending = w_neg;
        n_st.oor       = w_neg ? (n_st.mag > NEG_LIMIT) : (n_st.mag > POS_LIMIT);
        n_st.count     = (i_word.digit_count > 4'(NUM_DIGITS)) ? 4'(NUM_DIGITS)
                                                               : i_word.digit_count;
    end

    // stage register, valid cleared on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

/* design/sddf_digit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sddf_digit
// one digit stage: divide magnitude by ten and fill in one display position
// ----------------------------------------------------------------------------
module sddf_digit #(
    parameter int NUM_DIGITS = 8,
    parameter int POS        = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sddf_pkg::t_dstage            i_st,
    input  logic [NUM_DIGITS-1:0][3:0]   i_codes,
    output sddf_pkg::t_dstage            o_st,
    output logic [NUM_DIGITS-1:0][3:0]   o_codes
);
    import sddf_pkg::*;

    logic [63:0]               w_prod;
    logic [31:0]               w_quot;
    logic [31:0]               w_rem;
    logic [3:0]                w_code;
    t_dstage                   n_st;
    t_dstage                   r_st;
    logic [NUM_DIGITS-1:0][3:0] n_codes;
    logic [NUM_DIGITS-1:0][3:0] r_codes;

    // quotient and remainder by ten
    always_comb begin
        w_prod = {32'd0, i_st.mag} * {32'd0, RECIP_TEN};
        w_quot = 32'(w_prod >> RECIP_SHIFT);
        w_rem  = i_st.mag - ((w_quot << 3) + (w_quot << 1));
    end

    // code for this position and state for the next
    always_comb begin
        n_st   = i_st;
        w_code = CODE_BLANK;
        if (4'(POS) <= i_st.count) begin
            if (i_st.mag != 32'd0) begin
                w_code = w_rem[3:0];
            end else if (i_st.sign_pending) begin
                w_code            = CODE_MINUS;
                n_st.sign_pending = 1'b0;
            end else if ((POS == 1) && i_st.zero) begin
                w_code = 4'd0;
            end
            n_st.mag = w_quot;
        end
        n_codes          = i_codes;
        n_codes[POS-1]   = w_code;
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        r_codes <= n_codes;
        if (!i_rst_n) begin
            r_st <= '0;
        end else begin
            r_st <= n_st;
        end
    end

    assign o_st    = r_st;
    assign o_codes = r_codes;

endmodule

/* design/sddf_serializer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sddf_serializer
// emits the finished digit codes of one value as one word per cycle
// ----------------------------------------------------------------------------
module sddf_serializer #(
    parameter int NUM_DIGITS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic                       i_oor,
    input  logic [NUM_DIGITS-1:0][3:0] i_codes,
    output logic                       o_strobe,
    output sddf_pkg::t_out_word        o_word
);
    import sddf_pkg::*;

    localparam int IW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    logic                       r_active;
    logic [IW-1:0]              r_idx;
    logic                       r_oor;
    logic [NUM_DIGITS-1:0][3:0] r_codes;
    logic                       w_final;

    assign w_final = (r_idx == IW'(NUM_DIGITS - 1));

    // word index and load; a new value may load on the final word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
        end else if (i_load) begin
            r_active <= 1'b1;
            r_idx    <= '0;
        end else if (r_active) begin
            if (w_final) begin
                r_active <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // payload holding
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_codes <= i_codes;
            r_oor   <= i_oor;
        end
    end

    // output word
    always_comb begin
        o_strobe              = r_active;
        o_word.digit_position = 4'(r_idx) + 4'd1;
        o_word.digit_code     = r_codes[r_idx];
        o_word.out_of_range   = r_oor;
        o_word.last           = w_final;
    end

    // a load never cuts into a value still being emitted
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_active || w_final))
        else $error("digit load while previous value still emitting");

    // words of one value come in consecutive cycles
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && !w_final) |=> (r_active && r_idx == $past(r_idx) + 1'b1))
        else $error("digit word sequence broken");

    // a first word always follows a load
    a_first_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load) |=> (r_active && r_idx == '0))
        else $error("load did not start a new value");

endmodule

/* design/signed_decimal_digit_formatter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_decimal_digit_formatter_unit
// formats a signed 32-bit value as NUM_DIGITS code-B digit writes
// ----------------------------------------------------------------------------
// pacing: busy rises after each accept and holds off the next value, since the
//   single result port emits one word per cycle
// pipeline: one entry stage, then one divide-by-ten stage per display position
// reset: synchronous, clears all valid bits and the pacing counter; results
//   cannot be stalled by the receiver
module signed_decimal_digit_formatter_unit #(
    parameter int NUM_DIGITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  sddf_pkg::t_in_word  i_word,
    output logic                o_strobe,
    output sddf_pkg::t_out_word o_word
);
    import sddf_pkg::*;

    localparam int GW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    logic                       w_accept;
    logic [GW-1:0]              r_gap;
    t_dstage                    w_st    [0:NUM_DIGITS];
    logic [NUM_DIGITS-1:0][3:0] w_codes [0:NUM_DIGITS];

    // input pacing: busy holds off a new value after each accepted one
    assign w_accept = start && !busy;
    assign busy     = (r_gap != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= '0;
        end else if (w_accept) begin
            r_gap <= GW'(NUM_DIGITS - 1);
        end else if (r_gap != '0) begin
            r_gap <= r_gap - 1'b1;
        end
    end

    // entry stage
    sddf_prep #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_word   (i_word),
        .o_st     (w_st[0])
    );

    assign w_codes[0] = {NUM_DIGITS{CODE_BLANK}};

    // one stage per display position
    for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_digit
        sddf_digit #(
            .NUM_DIGITS (NUM_DIGITS),
            .POS        (k + 1)
        ) u_digit (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_st    (w_st[k]),
            .i_codes (w_codes[k]),
            .o_st    (w_st[k+1]),
            .o_codes (w_codes[k+1])
        );
    end

    // word output
    sddf_serializer #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_ser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_st[NUM_DIGITS].valid),
        .i_oor    (w_st[NUM_DIGITS].oor),
        .i_codes  (w_codes[NUM_DIGITS]),
        .o_strobe (o_strobe),
        .o_word   (o_word)
    );

endmodule

/* bench/signed_decimal_digit_formatter_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_decimal_digit_formatter_unit_tb
// self-checking bench for the code-B digit formatter: a directed table covers
// zero, both range limits, the most negative value, count saturation, count
// zero and dropped digits or sign, then random values of every shape follow;
// each accepted value is expanded into eight expected digit writes that are
// matched in order against the strobed output words
// ----------------------------------------------------------------------------
module signed_decimal_digit_formatter_unit_tb;
    import sddf_pkg::*;

    localparam int  NUM_POS     = 8;
    localparam time CLK_HALF    = 6ns;
    localparam int  RANDOM_WORDS = 86;
    localparam int  DRAIN_CYCLES = 2 * NUM_POS + 4;

    // one row of the directed table; codes hold position 1 in the low nibble
    typedef struct packed {
        logic signed [31:0] value;
        logic [3:0]         count;
        logic               typed;
        logic [31:0]        codes;
        logic               oor;
    } t_dir_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_word  i_word;
    logic      o_strobe;
    t_out_word o_word;

    t_out_word pending_digits[$];
    t_dir_row  dir_tab[$];
    int        bad_words;

    signed_decimal_digit_formatter_unit #(
        .NUM_DIGITS(NUM_POS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_word  (i_word),
        .o_strobe(o_strobe),
        .o_word  (o_word)
    );

    // clock
    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // run limit, far above the slowest legal run
    initial begin
        #2ms;
        $display("signed_decimal_digit_formatter_unit_tb: done, errors");
        $finish;
    end

    function automatic t_dir_row row(input logic signed [31:0] value, input logic [3:0] count,
                                     input logic typed, input logic [31:0] codes,
                                     input logic oor);
        t_dir_row r;
        r.value = value;
        r.count = count;
        r.typed = typed;
        r.codes = codes;
        r.oor   = oor;
        return r;
    endfunction

    // expected digit writes for one value, position 1 first
    task automatic predict_digits(input t_in_word w);
        logic [31:0] mag;
        logic        neg;
        logic        is_zero;
        logic        sign_left;
        logic        oor;
        logic [3:0]  cnt;
        t_out_word   dw;
        neg       = w.value[31];
        mag       = neg ? (32'd0 - w.value) : w.value;
        is_zero   = (w.value == 0);
        oor       = neg ? (mag > NEG_LIMIT) : (mag > POS_LIMIT);
        sign_left = neg;
        cnt       = (w.digit_count > NUM_POS) ? 4'(NUM_POS) : w.digit_count;
        for (int pos = 1; pos <= NUM_POS; pos++) begin
            dw.digit_code = CODE_BLANK;
            if (pos <= cnt) begin
                if (mag != 0) begin
                    dw.digit_code = 4'(mag % 10);
                end else if (sign_left) begin
                    dw.digit_code = CODE_MINUS;
                    sign_left     = 1'b0;
                end else if (pos == 1 && is_zero) begin
                    dw.digit_code = 4'd0;
                end
                mag = mag / 10;
            end
            dw.digit_position = 4'(pos);
            dw.out_of_range   = oor;
            dw.last           = (pos == NUM_POS);
            pending_digits.push_back(dw);
        end
    endtask

    // digit writes typed in by hand
    task automatic push_typed(input logic [31:0] codes, input logic oor);
        t_out_word dw;
        for (int pos = 1; pos <= NUM_POS; pos++) begin
            dw.digit_position = 4'(pos);
            dw.digit_code     = codes[4*(pos-1) +: 4];
            dw.out_of_range   = oor;
            dw.last           = (pos == NUM_POS);
            pending_digits.push_back(dw);
        end
    endtask

    // offer one word after an idle gap; returns at the accepting edge
    task automatic send_word(input t_in_word w, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_word <= w;
        forever begin
            @(negedge i_clk);
            if (!busy) break;
        end
        @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 1998)) - 999;
            2: v = $urandom_range(99999990, 100000010);
            3: v = -$signed($urandom_range(999995, 1000005));
            4: begin
                v = $urandom_range(0, 99999999);
                if ($urandom_range(0, 1)) v = -v;
            end
            default: begin
                v = $urandom_range(0, 20);
                v = $urandom_range(0, 1) ? (32'sh8000_0000 + v) : (32'sh7fff_ffff - v);
            end
        endcase
        return v;
    endfunction

    task automatic wait_drained();
        while (pending_digits.size() != 0) @(posedge i_clk);
    endtask

    // output checker, sampled mid-cycle while the word is stable
    always @(negedge i_clk) begin
        t_out_word want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (pending_digits.size() == 0) begin
                bad_words++;
                if (bad_words <= 10)
                    $display("unexpected word: pos %0d code %0d oor %0b last %0b",
                             o_word.digit_position, o_word.digit_code,
                             o_word.out_of_range, o_word.last);
            end else begin
                want = pending_digits.pop_front();
                if (o_word.digit_position !== want.digit_position ||
                    o_word.digit_code !== want.digit_code ||
                    o_word.out_of_range !== want.out_of_range ||
                    o_word.last !== want.last) begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("mismatch pos/code/oor/last: want %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                                 want.digit_position, want.digit_code, want.out_of_range,
                                 want.last, o_word.digit_position, o_word.digit_code,
                                 o_word.out_of_range, o_word.last);
                end
            end
        end
    end

    // stimulus
    initial begin
        t_in_word w;
        int       gap;
        bad_words = 0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_word  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: zero, limits, extremes, saturation, dropped digits
        dir_tab.push_back(row(0,            4'd8,  1'b1, 32'hFFFF_FFF0, 1'b0));
        dir_tab.push_back(row(0,            4'd0,  1'b1, 32'hFFFF_FFFF, 1'b0));
        dir_tab.push_back(row(99999999,     4'd8,  1'b1, 32'h9999_9999, 1'b0));
        dir_tab.push_back(row(100000000,    4'd8,  1'b1, 32'h0000_0000, 1'b1));
        dir_tab.push_back(row(-999999,      4'd8,  1'b1, 32'hFA99_9999, 1'b0));
        dir_tab.push_back(row(-1000000,     4'd8,  1'b1, 32'hA100_0000, 1'b1));
        dir_tab.push_back(row(32'sh8000_0000, 4'd8, 1'b1, 32'h4748_3648, 1'b1));
        dir_tab.push_back(row(2147483647,   4'd8,  1'b1, 32'h4748_3647, 1'b1));
        dir_tab.push_back(row(-1,           4'd8,  1'b1, 32'hFFFF_FFA1, 1'b0));
        dir_tab.push_back(row(-1,           4'd1,  1'b1, 32'hFFFF_FFF1, 1'b0));
        dir_tab.push_back(row(-5,           4'd15, 1'b1, 32'hFFFF_FFA5, 1'b0));
        dir_tab.push_back(row(12345,        4'd9,  1'b1, 32'hFFF1_2345, 1'b0));
        dir_tab.push_back(row(-42,          4'd0,  1'b1, 32'hFFFF_FFFF, 1'b0));
        dir_tab.push_back(row(123456789,    4'd3,  1'b1, 32'hFFFF_F789, 1'b1));
        dir_tab.push_back(row(-123,         4'd3,  1'b1, 32'hFFFF_F123, 1'b0));
        dir_tab.push_back(row(-123,         4'd4,  1'b1, 32'hFFFF_A123, 1'b0));
        dir_tab.push_back(row(0,            4'd1,  1'b1, 32'hFFFF_FFF0, 1'b0));
        dir_tab.push_back(row(100,          4'd8,  1'b1, 32'hFFFF_F100, 1'b0));
        dir_tab.push_back(row(-999999,      4'd6,  1'b1, 32'hFF99_9999, 1'b0));
        dir_tab.push_back(row(-2147483647,  4'd4,  1'b1, 32'hFFFF_3647, 1'b1));
        dir_tab.push_back(row(32'sh5555_5555, 4'd10, 1'b0, '0, 1'b0));
        dir_tab.push_back(row(32'shAAAA_AAAA, 4'd7,  1'b0, '0, 1'b0));
        dir_tab.push_back(row(-7,           4'd2,  1'b0, '0, 1'b0));
        dir_tab.push_back(row(1000000,      4'd5,  1'b0, '0, 1'b0));

        foreach (dir_tab[i]) begin
            w.value       = dir_tab[i].value;
            w.digit_count = dir_tab[i].count;
            gap = (i < 8) ? 0 : $urandom_range(0, 14);
            send_word(w, gap);
            if (dir_tab[i].typed) push_typed(dir_tab[i].codes, dir_tab[i].oor);
            else predict_digits(w);
        end

        // hold off until the directed part has fully drained
        start <= 1'b0;
        wait_drained();

        // random part, with back-to-back stretches between idle ones
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            w.value       = rand_value();
            w.digit_count = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                                         : 4'($urandom_range(0, 8));
            gap = ((n / 16) % 3 == 1) ? 0 : $urandom_range(0, 14);
            if (n == RANDOM_WORDS / 2) begin
                start <= 1'b0;
                wait_drained();
                gap = 0;
            end
            send_word(w, gap);
            predict_digits(w);
        end
        start <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (bad_words == 0 && pending_digits.size() == 0) begin
            $display("signed_decimal_digit_formatter_unit_tb: done, clean");
        end else begin
            $display("signed_decimal_digit_formatter_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
